// File: rtl/imu_fwd_pkg.sv
package imu_fwd_pkg;

    localparam logic [4:0] TAG_GYRO  = 5'd1;
    localparam logic [4:0] TAG_ACCEL = 5'd2;
    localparam logic [4:0] TAG_ROT   = 5'd19;

    localparam logic CFG_GYRO  = 1'b0;
    localparam logic CFG_ACCEL = 1'b1;

    localparam logic [31:0] GYRO_RESET  = 32'd327953;
    localparam logic [31:0] ACCEL_RESET = 32'd25692752;

    localparam int AXES       = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    typedef struct packed {
        logic [4:0]         sample_tag;
        logic signed [15:0] word_x;
        logic signed [15:0] word_y;
        logic signed [15:0] word_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic [30:0]        quat_w;
        logic               tag_known;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GYRO,
        KIND_ACCEL,
        KIND_ROT
    } t_kind;

    typedef struct packed {
        logic       cap;
        logic       mul_go;
        logic [1:0] idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       quat_small_wr;
        logic       div_init;
        logic       div_step;
        logic       div_wr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  small_fit;
        logic  out_free;
    } t_status;

endpackage

// File: rtl/imu_fwd_stream_if.sv
interface imu_fwd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/imu_fifo_word_decoder_top.sv
// IMU FIFO word decoder.
// i_in (sink) takes one request per FIFO word: tag plus three axis words.
// o_out (source) returns one result per request with every held value:
// angular rates and accelerations in Q16.16, quaternion in Q1.30.
// i_cfg_we/i_cfg_idx/i_cfg_data write the gyro (index 0) or accel (index 1)
// scale factor; write only while no request is in flight.
// One request is processed at a time; i_in.ready is high while idle.
// Work between accept and o_out.valid, by tag:
//   unknown tag: none; gyro or accel: 3 products through
//   one shared 33x33 multiplier;
//   rotation: 3 squares on the same multiplier, then a 32-step square root;
//   rotation outside the unit sphere: also three 31-step divides.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next result waits in the
// controller until the register frees.
// Reset clears all held values and loads the default scale factors.
module imu_fifo_word_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    imu_fwd_stream_if.sink       i_in,
    imu_fwd_stream_if.source     o_out
);
    import imu_fwd_pkg::*;

    t_cmd    cmd;
    t_status status;

    imu_fwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    imu_fwd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

// File: rtl/imu_fwd_ctrl.sv
module imu_fwd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  imu_fwd_pkg::t_status  i_status,
    output imu_fwd_pkg::t_cmd     o_cmd
);
    import imu_fwd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_MUL,
        S_SQINIT,
        S_SQRT,
        S_QSEL,
        S_DIV_INIT,
        S_DIV,
        S_DIV_WR,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [4:0] r_cnt;
    logic [1:0] r_idx;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.cap = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul_go = (r_cnt < 5'(AXES));
                o_cmd.idx    = r_cnt[1:0];
            end
            S_SQINIT: begin
                o_cmd.sqrt_init = 1'b1;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            S_QSEL: begin
                o_cmd.quat_small_wr = i_status.small_fit;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DIV_WR: begin
                o_cmd.div_wr = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_cnt <= '0;
                    if (i_status.kind == KIND_NONE) r_state <= S_OUT;
                    else r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(AXES)) begin
                        r_cnt <= '0;
                        if (i_status.kind == KIND_ROT) r_state <= S_SQINIT;
                        else r_state <= S_OUT;
                    end
                end
                S_SQINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_STEPS - 1)) r_state <= S_QSEL;
                end
                S_QSEL: begin
                    r_idx <= '0;
                    if (i_status.small_fit) r_state <= S_OUT;
                    else r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) r_state <= S_DIV_WR;
                end
                S_DIV_WR: begin
                    if (r_idx == 2'(AXES - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_OUT: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/imu_fwd_datapath.sv
module imu_fwd_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [31:0]            i_cfg_data,
    input  imu_fwd_pkg::t_in_item  i_item,
    input  imu_fwd_pkg::t_cmd      i_cmd,
    output imu_fwd_pkg::t_status   o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output imu_fwd_pkg::t_out_item o_out_data
);
    import imu_fwd_pkg::*;

    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

    logic [31:0]        r_gyro_sf;
    logic [31:0]        r_accel_sf;
    t_kind              r_kind;
    logic signed [15:0] r_word [AXES];
    logic [30:0]        r_mag [AXES];
    logic               r_neg [AXES];
    logic               r_small;
    logic signed [65:0] r_prod;
    logic               r_pv;
    logic [1:0]         r_pidx;
    logic [63:0]        r_sum;
    logic [63:0]        r_n;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [32:0]        r_rem;
    logic               r_din;
    logic [30:0]        r_quo;
    logic signed [31:0] r_rate [AXES];
    logic signed [31:0] r_accel [AXES];
    logic signed [31:0] r_quat [AXES];
    logic [30:0]        r_qw;
    logic               r_ovld;
    t_out_item          r_out;

    logic [15:0]        h [AXES];
    logic [4:0]         ex [AXES];
    logic [10:0]        sig [AXES];
    logic [4:0]         maxe;
    logic [30:0]        n_mag [AXES];
    t_kind              n_kind;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] rnd;
    logic signed [65:0] shq;
    logic signed [31:0] sat;
    logic [63:0]        trial;
    logic [32:0]        dt;
    logic [31:0]        root;
    logic [30:0]        qc;
    logic               small_fit;

    always_comb begin
        h[0] = i_item.word_x;
        h[1] = i_item.word_y;
        h[2] = i_item.word_z;
        maxe = 5'd1;
        for (int i = 0; i < AXES; i++) begin
            ex[i]  = (h[i][14:10] == 5'd0) ? 5'd1 : h[i][14:10];
            sig[i] = (h[i][14:10] == 5'd0) ? {1'b0, h[i][9:0]} : {1'b1, h[i][9:0]};
            if (ex[i] > maxe) maxe = ex[i];
        end
        for (int i = 0; i < AXES; i++) begin
            if (maxe <= 5'd15) n_mag[i] = 31'(sig[i]) << (ex[i] + 5'd5);
            else n_mag[i] = 31'({sig[i], 19'd0} >> (maxe - ex[i]));
        end
        case (i_item.sample_tag)
            TAG_GYRO:  n_kind = KIND_GYRO;
            TAG_ACCEL: n_kind = KIND_ACCEL;
            TAG_ROT:   n_kind = KIND_ROT;
            default:   n_kind = KIND_NONE;
        endcase
    end

    always_comb begin
        if (r_kind == KIND_ROT) begin
            mul_a = 33'(r_mag[i_cmd.idx]);
            mul_b = 33'(r_mag[i_cmd.idx]);
        end else begin
            mul_a = 33'(r_word[i_cmd.idx]);
            mul_b = {1'b0, (r_kind == KIND_GYRO) ? r_gyro_sf : r_accel_sf};
        end
        rnd = r_prod + 66'sd32768;
        shq = rnd >>> 16;
        if (shq > 66'sd2147483647) sat = 32'sh7FFFFFFF;
        else if (shq < -66'sd2147483648) sat = 32'sh80000000;
        else sat = shq[31:0];
        trial = r_res + r_bit;
        root  = r_res[31:0];
        dt    = {r_rem[31:0], r_din};
        if (root == 32'd0) qc = '0;
        else if (r_quo > ONE_Q30) qc = ONE_Q30;
        else qc = r_quo;
        small_fit = r_small && (r_sum <= ONE_Q60);
    end

    assign o_status.kind      = r_kind;
    assign o_status.small_fit = small_fit;
    assign o_status.out_free  = !r_ovld || i_out_ready;
    assign o_out_valid        = r_ovld;
    assign o_out_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_sf  <= GYRO_RESET;
            r_accel_sf <= ACCEL_RESET;
            r_kind     <= KIND_NONE;
            r_pv       <= 1'b0;
            r_ovld     <= 1'b0;
            r_qw       <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_rate[i]  <= '0;
                r_accel[i] <= '0;
                r_quat[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GYRO) r_gyro_sf <= i_cfg_data;
                else r_accel_sf <= i_cfg_data;
            end
            if (i_cmd.cap) begin
                r_kind  <= n_kind;
                r_small <= (maxe <= 5'd15);
                r_sum   <= '0;
                for (int i = 0; i < AXES; i++) begin
                    r_word[i] <= h[i];
                    r_mag[i]  <= n_mag[i];
                    r_neg[i]  <= h[i][15];
                end
            end
            r_pv   <= i_cmd.mul_go;
            r_pidx <= i_cmd.idx;
            if (i_cmd.mul_go) r_prod <= mul_a * mul_b;
            if (r_pv) begin
                case (r_kind)
                    KIND_GYRO:  r_rate[r_pidx]  <= sat;
                    KIND_ACCEL: r_accel[r_pidx] <= sat;
                    KIND_ROT:   r_sum <= r_sum + r_prod[63:0];
                    default:    r_sum <= r_sum;
                endcase
            end
            if (i_cmd.sqrt_init) begin
                r_n   <= small_fit ? (ONE_Q60 - r_sum) : r_sum;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            if (i_cmd.sqrt_step) begin
                if (r_n >= trial) begin
                    r_n   <= r_n - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.quat_small_wr) begin
                for (int i = 0; i < AXES; i++) begin
                    r_quat[i] <= r_neg[i] ? -32'(r_mag[i]) : 32'(r_mag[i]);
                end
                r_qw <= r_res[30:0];
            end
            if (i_cmd.div_init) begin
                r_rem <= 33'(r_mag[i_cmd.idx] >> 1);
                r_din <= r_mag[i_cmd.idx][0];
                r_quo <= '0;
            end
            if (i_cmd.div_step) begin
                if (dt >= {1'b0, root}) begin
                    r_rem <= dt - {1'b0, root};
                    r_quo <= {r_quo[29:0], 1'b1};
                end else begin
                    r_rem <= dt;
                    r_quo <= {r_quo[29:0], 1'b0};
                end
                r_din <= 1'b0;
            end
            if (i_cmd.div_wr) begin
                r_quat[i_cmd.idx] <= r_neg[i_cmd.idx] ? -32'(qc) : 32'(qc);
                r_qw <= '0;
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
                r_out.rate_x    <= r_rate[0];
                r_out.rate_y    <= r_rate[1];
                r_out.rate_z    <= r_rate[2];
                r_out.accel_x   <= r_accel[0];
                r_out.accel_y   <= r_accel[1];
                r_out.accel_z   <= r_accel[2];
                r_out.quat_x    <= r_quat[0];
                r_out.quat_y    <= r_quat[1];
                r_out.quat_z    <= r_quat[2];
                r_out.quat_w    <= r_qw;
                r_out.tag_known <= (r_kind != KIND_NONE);
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_sqrt_bit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_bit != 64'd0))
        else $error("square root stepped past its last bit");
    a_div_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (root != 32'd0))
        else $error("divide by a zero norm");
    a_quo_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_wr |-> (r_quo <= ONE_Q30))
        else $error("normalized component above one");
    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovld || i_out_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// File: sim/tb_imu_fifo_word_decoder_top.sv
module tb_imu_fifo_word_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_fwd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_GYRO;
    logic [31:0] i_cfg_data = '0;

    imu_fwd_stream_if #(.T(t_in_item))  req_if ();
    imu_fwd_stream_if #(.T(t_out_item)) res_if ();

    imu_fifo_word_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if.sink),
        .o_out      (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    t_in_item    pending_reqs[$];
    t_out_item   expected_words[$];
    logic [31:0] gyro_factor;
    logic [31:0] accel_factor;
    logic signed [31:0] rate_hold[3];
    logic signed [31:0] accel_hold[3];
    logic signed [31:0] quat_hold[4];
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          req_gap = 0;
    int          res_gap = 0;
    bit          req_taken = 1'b0;
    bit          res_taken = 1'b0;

    function automatic logic signed [31:0] scale_axis(logic [15:0] word, logic [31:0] factor);
        longint p;
        longint q;
        p = longint'($signed(word)) * longint'({32'b0, factor}) + 32768;
        q = p >>> 16;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic decode_quat(input logic [15:0] words[3]);
        logic [31:0] sig[3];
        logic [31:0] ex[3];
        logic        neg[3];
        logic [63:0] mag[3];
        logic [63:0] sumsq;
        logic [63:0] root;
        logic [63:0] q;
        logic [31:0] maxe;
        maxe = 1;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = words[i][15];
            ex[i] = words[i][14:10] != 0 ? words[i][14:10] : 1;
            sig[i] = words[i][14:10] != 0 ? 1024 + words[i][9:0] : words[i][9:0];
            if (ex[i] > maxe) maxe = ex[i];
        end
        if (maxe <= 15) begin
            for (int i = 0; i < 3; i++) begin
                mag[i] = 64'(sig[i]) << (ex[i] + 5);
                sumsq += mag[i] * mag[i];
            end
            if (sumsq <= (64'd1 << 60)) begin
                for (int i = 0; i < 3; i++)
                    quat_hold[i] = neg[i] ? -mag[i][31:0] : mag[i][31:0];
                root = int_sqrt((64'd1 << 60) - sumsq);
                quat_hold[3] = root[31:0];
                return;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                mag[i] = (64'(sig[i]) << 19) >> (maxe - ex[i]);
                sumsq += mag[i] * mag[i];
            end
        end
        root = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++) begin
            q = root != 0 ? (mag[i] << 30) / root : 0;
            if (q > 64'd1 << 30) q = 64'd1 << 30;
            quat_hold[i] = neg[i] ? -q[31:0] : q[31:0];
        end
        quat_hold[3] = 0;
    endtask

    task automatic predict_word(input t_in_item req);
        t_out_item   res;
        logic [15:0] words[3];
        words[0] = req.word_x;
        words[1] = req.word_y;
        words[2] = req.word_z;
        res.tag_known = 1'b1;
        case (req.sample_tag)
            TAG_GYRO: begin
                for (int i = 0; i < 3; i++) rate_hold[i] = scale_axis(words[i], gyro_factor);
            end
            TAG_ACCEL: begin
                for (int i = 0; i < 3; i++) accel_hold[i] = scale_axis(words[i], accel_factor);
            end
            TAG_ROT: decode_quat(words);
            default: res.tag_known = 1'b0;
        endcase
        res.rate_x = rate_hold[0];
        res.rate_y = rate_hold[1];
        res.rate_z = rate_hold[2];
        res.accel_x = accel_hold[0];
        res.accel_y = accel_hold[1];
        res.accel_z = accel_hold[2];
        res.quat_x = quat_hold[0];
        res.quat_y = quat_hold[1];
        res.quat_z = quat_hold[2];
        res.quat_w = quat_hold[3][30:0];
        expected_words.push_back(res);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                req_taken = 1'b0;
                req_if.valid <= 1'b0;
                req_gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
            end else if (!req_if.valid && pending_reqs.size() > 0) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else begin
                    req_if.data <= pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                end
            end
            if (res_taken) begin
                res_taken = 1'b0;
                res_gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
                res_if.ready <= res_gap == 0;
            end else if (res_gap > 0) begin
                res_gap--;
                res_if.ready <= res_gap == 0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end else begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
            res_if.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (req_if.valid && req_if.ready) begin
                predict_word(req_if.data);
                req_taken = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                res_taken = 1'b1;
                if (expected_words.size() == 0) begin
                    $error("result with no request pending");
                    n_errors++;
                end else begin
                    t_out_item e;
                    t_out_item a;
                    e = expected_words.pop_front();
                    a = res_if.data;
                    if (a.rate_x !== e.rate_x) begin
                        $error("rate_x exp %0d got %0d", e.rate_x, a.rate_x); n_errors++;
                    end
                    if (a.rate_y !== e.rate_y) begin
                        $error("rate_y exp %0d got %0d", e.rate_y, a.rate_y); n_errors++;
                    end
                    if (a.rate_z !== e.rate_z) begin
                        $error("rate_z exp %0d got %0d", e.rate_z, a.rate_z); n_errors++;
                    end
                    if (a.accel_x !== e.accel_x) begin
                        $error("accel_x exp %0d got %0d", e.accel_x, a.accel_x); n_errors++;
                    end
                    if (a.accel_y !== e.accel_y) begin
                        $error("accel_y exp %0d got %0d", e.accel_y, a.accel_y); n_errors++;
                    end
                    if (a.accel_z !== e.accel_z) begin
                        $error("accel_z exp %0d got %0d", e.accel_z, a.accel_z); n_errors++;
                    end
                    if (a.quat_x !== e.quat_x) begin
                        $error("quat_x exp %0d got %0d", e.quat_x, a.quat_x); n_errors++;
                    end
                    if (a.quat_y !== e.quat_y) begin
                        $error("quat_y exp %0d got %0d", e.quat_y, a.quat_y); n_errors++;
                    end
                    if (a.quat_z !== e.quat_z) begin
                        $error("quat_z exp %0d got %0d", e.quat_z, a.quat_z); n_errors++;
                    end
                    if (a.quat_w !== e.quat_w) begin
                        $error("quat_w exp %0d got %0d", e.quat_w, a.quat_w); n_errors++;
                    end
                    if (a.tag_known !== e.tag_known) begin
                        $error("tag_known exp %0d got %0d", e.tag_known, a.tag_known);
                        n_errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_in_item make_req(logic [4:0] tag, logic [15:0] x, logic [15:0] y,
                                          logic [15:0] z);
        t_in_item r;
        r.sample_tag = tag;
        r.word_x = x;
        r.word_y = y;
        r.word_z = z;
        return r;
    endfunction

    function automatic logic [15:0] rand_half(int mode);
        logic [15:0] h;
        h = 16'($urandom);
        case (mode)
            0: h[14:10] = 5'($urandom_range(0, 14));
            1: h[14:10] = 5'($urandom_range(10, 15));
            default: ;
        endcase
        return h;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_factor(logic idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_GYRO) gyro_factor = value;
        else accel_factor = value;
    endtask

    function automatic logic [4:0] rand_tag();
        case ($urandom_range(0, 9))
            0, 1, 2: return TAG_GYRO;
            3, 4, 5: return TAG_ACCEL;
            6, 7, 8: return TAG_ROT;
            default: return 5'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] gyro_set[6];
        logic [31:0] accel_set[6];
        logic [4:0]  tag;
        int          mode;
        gyro_factor = GYRO_RESET;
        accel_factor = ACCEL_RESET;
        for (int i = 0; i < 3; i++) begin
            rate_hold[i] = 0;
            accel_hold[i] = 0;
        end
        for (int i = 0; i < 4; i++) quat_hold[i] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_reqs.push_back(make_req(TAG_GYRO, 16'h7FFF, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(TAG_ACCEL, 16'hFFFF, 16'h0001, 16'h8000));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h0000, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h3C00, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h3800, 16'hB800, 16'h3800));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h3C00, 16'h3C00, 16'hBC00));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h7FFF, 16'h0001, 16'hFC00));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h03FF, 16'h8001, 16'h0400));
        pending_reqs.push_back(make_req(TAG_ROT, 16'h4000, 16'h7C00, 16'h0000));
        pending_reqs.push_back(make_req(5'd0, 16'h1234, 16'h5678, 16'h9ABC));
        pending_reqs.push_back(make_req(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(5'd18, 16'h0000, 16'h0000, 16'h0000));
        wait_drained();
        write_factor(CFG_GYRO, 32'hFFFF_FFFF);
        write_factor(CFG_ACCEL, 32'hFFFF_FFFF);
        pending_reqs.push_back(make_req(TAG_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF));
        pending_reqs.push_back(make_req(TAG_ACCEL, 16'h8000, 16'h7FFF, 16'h0001));
        wait_drained();

        gyro_set = '{32'd0, 32'hFFFF_FFFF, GYRO_RESET, 32'h8000_0000, 32'h0, 32'h0};
        accel_set = '{32'hFFFF_FFFF, 32'd0, ACCEL_RESET, 32'h0, 32'h0, 32'h0};
        for (int phase = 0; phase < 6; phase++) begin
            if (phase >= 3) begin
                gyro_set[phase] = $urandom;
                accel_set[phase] = $urandom;
            end
            write_factor(CFG_GYRO, gyro_set[phase]);
            write_factor(CFG_ACCEL, accel_set[phase]);
            for (int n = 0; n < 205; n++) begin
                tag = rand_tag();
                mode = $urandom_range(0, 3);
                if (tag == TAG_ROT)
                    pending_reqs.push_back(make_req(tag, rand_half(mode), rand_half(mode),
                                                    rand_half(mode)));
                else
                    pending_reqs.push_back(make_req(tag, 16'($urandom), 16'($urandom),
                                                    16'($urandom)));
            end
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
